// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the CAN channel extractor.
// Expects a clock clk_i and an active-low reset rst_ni in the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  `ASSERT_CLK(lbl, !(cond), msg)

`endif

// ===== rtl/ccx_pkg.sv =====
// Package for the CAN channel extractor: word types, reset values,
// register indexes and the fixed channel layout table. No dependencies.
package ccx_pkg;

  localparam int unsigned PosW          = 16;
  localparam int unsigned CursorW       = 5;
  localparam int unsigned NumChannelsDef = 18;
  localparam int unsigned BytesPerFrame = 8;

  localparam logic [31:0] MatchIdReset   = 32'h0000_05F0;
  localparam logic [23:0] EndMarkerReset = 24'hFC_FBFA;

  // configuration register indexes
  localparam logic CfgMatchId   = 1'b0;
  localparam logic CfgEndMarker = 1'b1;

  typedef struct packed {
    logic [31:0] frame_identifier;
    logic [3:0]  data_length;
    logic [63:0] frame_bytes;
  } ccx_in_t;

  typedef struct packed {
    logic [CursorW-1:0] channel_number;
    logic signed [63:0] channel_value;
    logic               last_of_frame;
  } ccx_out_t;

  typedef struct packed {
    logic [PosW-1:0] offset;
    logic [3:0]      width;
  } ccx_layout_t;

  // Fixed layout; entries past the listed channels sit at offset 0, two bytes wide.
  function automatic ccx_layout_t layout_entry(logic [CursorW-1:0] idx);
    ccx_layout_t e;
    e.width = 4'd2;
    unique case (idx)
      5'd0:    e.offset = 16'd0;
      5'd1:    e.offset = 16'd2;
      5'd2:    e.offset = 16'd4;
      5'd3:    e.offset = 16'd6;
      5'd4:    e.offset = 16'd8;
      5'd5:    e.offset = 16'd10;
      5'd6:    e.offset = 16'd22;
      5'd7:    e.offset = 16'd24;
      5'd8:    e.offset = 16'd44;
      5'd9:    e.offset = 16'd46;
      5'd10:   e.offset = 16'd48;
      5'd11:   e.offset = 16'd50;
      5'd12:   e.offset = 16'd52;
      5'd13:   e.offset = 16'd54;
      5'd14:   e.offset = 16'd56;
      5'd15:   e.offset = 16'd58;
      5'd16:   e.offset = 16'd60;
      5'd17:   e.offset = 16'd88;
      default: e.offset = 16'd0;
    endcase
    return e;
  endfunction

endpackage

// ===== rtl/can_channel_extractor_unit.sv =====
// CAN channel extractor top level: frame walker, channel shifter and output register.
// Depends on ccx_pkg and assert_macros.svh.
//
// Usage: one CAN frame word enters on in_valid_i/in_ready_o. Frames whose
// identifier differs from the match_identifier register are dropped in the
// cycle they are taken. A matching frame is walked one data byte per cycle
// unless a hit stalls on a full output (data_length, clamped to eight), then
// a closing step; in_ready_o stays low until the walker is idle again. The
// walk step is the only loop; one 64-bit shifter extracts the channel bytes
// at the current byte.
// Each channel hit yields one result word on out_valid_o/out_ready_i. A hit is
// held in a pending register until the next hit so that last_of_frame can be
// set on the final word of the frame; the first word leaves at the second
// hit or at the closing step. The output register lets a new frame be taken
// while a result still waits; when the receiver stalls with both pending and
// output full, the walk holds until the output drains.
// Configuration: cfg_we_i writes register cfg_idx_i (0 match identifier,
// 1 end marker) at once; write only while idle.
// Reset: byte position and channel cursor return to zero, registers to their
// defaults, no result is pending.
module can_channel_extractor_unit
  import ccx_pkg::*;
#(
  parameter int unsigned NUM_CHANNELS = NumChannelsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  ccx_in_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output ccx_out_t    out_data_o,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_wdata_i
);

  `include "assert_macros.svh"

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_WALK  = 3'b010,
    S_CLOSE = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [31:0]        match_id_q, match_id_d;
  logic [23:0]        end_marker_q, end_marker_d;
  logic [PosW-1:0]    pos_q, pos_d;
  logic [CursorW-1:0] cursor_q, cursor_d;
  logic [3:0]         len_q, len_d;
  logic [3:0]         step_q, step_d;
  logic               marker_hit_q, marker_hit_d;
  logic [63:0]        frame_q, frame_d;
  logic               pend_valid_q, pend_valid_d;
  ccx_out_t           pend_q, pend_d;
  logic               out_valid_q, out_valid_d;
  ccx_out_t           out_q, out_d;

  ccx_layout_t        lay;
  logic               hit;
  logic               out_free;
  logic [3:0]         width_c;
  logic [3:0]         width_gap;
  logic signed [63:0] aligned;
  logic signed [63:0] chan_val;
  logic [CursorW:0]   cursor_inc;
  logic [CursorW-1:0] cursor_next;
  logic               id_match;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_free    = !out_valid_q || out_ready_i;
  assign id_match    = (in_data_i.frame_identifier == match_id_q);

  // channel shifter: bring byte step to the top, then arithmetic shift down
  always_comb begin
    lay = layout_entry(cursor_q);
    hit = (pos_q == lay.offset);
    if (lay.width == 4'd0) begin
      width_c = 4'd1;
    end else if (lay.width > 4'(BytesPerFrame)) begin
      width_c = 4'(BytesPerFrame);
    end else begin
      width_c = lay.width;
    end
    width_gap  = 4'(BytesPerFrame) - width_c;
    aligned    = $signed(frame_q << {step_q[2:0], 3'b000});
    chan_val   = aligned >>> {width_gap[2:0], 3'b000};
    cursor_inc = {1'b0, cursor_q} + {{CursorW{1'b0}}, 1'b1};
    if (cursor_inc >= (CursorW+1)'(NUM_CHANNELS)) begin
      cursor_next = '0;
    end else begin
      cursor_next = cursor_inc[CursorW-1:0];
    end
  end

  always_comb begin
    state_d      = state_q;
    match_id_d   = match_id_q;
    end_marker_d = end_marker_q;
    pos_d        = pos_q;
    cursor_d     = cursor_q;
    len_d        = len_q;
    step_d       = step_q;
    marker_hit_d = marker_hit_q;
    frame_d      = frame_q;
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q && !out_ready_i;

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgMatchId:   match_id_d   = cfg_wdata_i;
        CfgEndMarker: end_marker_d = cfg_wdata_i[23:0];
        default:      match_id_d   = match_id_q;
      endcase
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && id_match) begin
          frame_d      = in_data_i.frame_bytes;
          len_d        = in_data_i.data_length[3] ? 4'(BytesPerFrame)
                                                  : in_data_i.data_length;
          step_d       = '0;
          marker_hit_d = (in_data_i.frame_bytes[31:8] == end_marker_q);
          state_d      = S_WALK;
        end
      end
      S_WALK: begin
        if (step_q == len_q) begin
          state_d = S_CLOSE;
        end else if (!(hit && pend_valid_q && !out_free)) begin
          // advance one byte; a hit pushes the older pending word out
          if (hit) begin
            if (pend_valid_q) begin
              out_d       = pend_q;
              out_valid_d = 1'b1;
            end
            pend_valid_d          = 1'b1;
            pend_d.channel_number = cursor_q;
            pend_d.channel_value  = chan_val;
            pend_d.last_of_frame  = 1'b0;
            cursor_d              = cursor_next;
          end
          pos_d  = pos_q + 1'b1;
          step_d = step_q + 1'b1;
        end
      end
      S_CLOSE: begin
        if (!pend_valid_q || out_free) begin
          if (pend_valid_q) begin
            out_d               = pend_q;
            out_d.last_of_frame = 1'b1;
            out_valid_d         = 1'b1;
            pend_valid_d        = 1'b0;
          end
          if (marker_hit_q) begin
            pos_d    = '0;
            cursor_d = '0;
          end
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      match_id_q   <= MatchIdReset;
      end_marker_q <= EndMarkerReset;
      pos_q        <= '0;
      cursor_q     <= '0;
      len_q        <= '0;
      step_q       <= '0;
      marker_hit_q <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      match_id_q   <= match_id_d;
      end_marker_q <= end_marker_d;
      pos_q        <= pos_d;
      cursor_q     <= cursor_d;
      len_q        <= len_d;
      step_q       <= step_d;
      marker_hit_q <= marker_hit_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    frame_q <= frame_d;
    pend_q  <= pend_d;
    out_q   <= out_d;
  end

  `ASSERT_NEVER(a_idle_no_pending, in_ready_o && pend_valid_q,
                "pending word left behind at end of frame")
  `ASSERT_CLK(a_cursor_range, ({1'b0, cursor_q} < (CursorW+1)'(NUM_CHANNELS)),
              "channel cursor past last channel")
  `ASSERT_NEVER(a_step_range, (state_q == S_WALK) && (step_q > len_q),
                "walk step beyond frame length")
  `ASSERT_CLK(a_stall_holds, (state_q == S_WALK && step_q != len_q && hit &&
              pend_valid_q && !out_free) |=> ($stable(pos_q) && $stable(cursor_q)),
              "walk advanced while output was blocked")

endmodule
